[design/mof_pkg.sv]
// Shared constants for the median-of-five sliding-window filter.
`timescale 1ns / 1ps
`default_nettype none
package mof_pkg;

  localparam int unsigned WINDOW_SIZE_DEF  = 5;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

endpackage
`default_nettype wire

[design/mof_cell.sv]
// One window cell: holds a sample, shifts it on, and ranks the shifted value.
`timescale 1ns / 1ps
`default_nettype none
module mof_cell #(
  parameter int unsigned WINDOW_SIZE  = mof_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned SAMPLE_WIDTH = mof_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned INDEX        = 0
) (
  input  wire                           clk,
  input  wire                           shift_en,
  input  wire logic signed [SAMPLE_WIDTH-1:0] d_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0] win_nxt [WINDOW_SIZE],
  output logic signed [SAMPLE_WIDTH-1:0]      q,
  output logic signed [SAMPLE_WIDTH-1:0]      q_nxt,
  output logic                                is_mid
);

  localparam int unsigned RankWidth = $clog2(WINDOW_SIZE);
  localparam int unsigned MidRank   = (WINDOW_SIZE - 1) / 2;

  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic        [RankWidth-1:0]    rank;

  assign q_nxt = shift_en ? d_in : sample_r;
  assign q     = sample_r;

  always_ff @(posedge clk) begin
    sample_r <= q_nxt;
  end

  // Stable rank: strictly smaller values, plus equal values in lower cells.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if (j != INDEX) begin
        if ((win_nxt[j] < win_nxt[INDEX]) ||
            ((win_nxt[j] == win_nxt[INDEX]) && (j < INDEX))) begin
          rank = rank + RankWidth'(1);
        end
      end
    end
  end

  assign is_mid = (rank == RankWidth'(MidRank));

endmodule
`default_nettype wire

[design/median_of_five_filter.sv]
// Top level of the sliding-window median filter.
//
// Input channel in_valid / in_sample / in_stall, result channel
// out_valid / out_median / out_stall. A transfer happens on a rising edge
// with valid high and stall low.
// Samples shift through a row of WINDOW_SIZE cells, newest in cell 0. Each
// cell ranks its shifted value against the others in the same cycle, and
// the cell holding the middle rank drives the result register.
// The result is registered and appears on out_* in the cycle after the input transfer.
// Throughput: one sample per cycle while in_stall is low.
// The first WINDOW_SIZE-1 samples after reset fill the window and give no
// result; every sample after that gives exactly one.
// Reset (rst_n low, synchronous) empties the window and drops any pending
// result. While out_stall holds a pending result, in_stall is raised; a
// result taken in the same cycle frees the slot for the next sample.
`timescale 1ns / 1ps
`default_nettype none
module median_of_five_filter #(
  parameter int unsigned WINDOW_SIZE  = mof_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned SAMPLE_WIDTH = mof_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                                in_stall,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      out_median,
  input  wire                                 out_stall
);

  localparam int unsigned FillWidth = $clog2(WINDOW_SIZE + 1);

  logic                           accept;
  logic                           full_after;
  logic [FillWidth-1:0]           fill_r, fill_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] median_r, median_nxt;

  logic signed [SAMPLE_WIDTH-1:0] cell_q   [WINDOW_SIZE];
  logic signed [SAMPLE_WIDTH-1:0] cell_nxt [WINDOW_SIZE];
  logic        [WINDOW_SIZE-1:0]  cell_mid;

  assign in_stall   = out_valid_r && out_stall;
  assign accept     = in_valid && !in_stall;
  assign full_after = (fill_r >= FillWidth'(WINDOW_SIZE - 1));

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] d_in;
    if (i == 0) begin : g_head
      assign d_in = in_sample;
    end else begin : g_body
      assign d_in = cell_q[i-1];
    end
    mof_cell #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .shift_en(accept),
      .d_in    (d_in),
      .win_nxt (cell_nxt),
      .q       (cell_q[i]),
      .q_nxt   (cell_nxt[i]),
      .is_mid  (cell_mid[i])
    );
  end

  always_comb begin
    median_nxt = median_r;
    if (accept && full_after) begin
      median_nxt = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        if (cell_mid[i]) begin
          median_nxt = median_nxt | cell_nxt[i];
        end
      end
    end
  end

  always_comb begin
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      if (!full_after) begin
        fill_nxt = fill_r + FillWidth'(1);
      end else begin
        fill_nxt      = FillWidth'(WINDOW_SIZE);
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = median_r;

endmodule
`default_nettype wire
